>>> design/ssbts_pkg.sv
// ----------------------------------------------------------------------------
// ssbts_pkg: shared types and constants of the beat trend store
// Payload structs, request codes, register defaults and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ssbts_pkg;

   localparam int TIME_W = 40;
   localparam int RATE_W = 12;
   localparam int LEN_W  = 24;
   localparam int KICK_W = 16;
   localparam int OSUM_W = 28;
   localparam int KSUM_W = 20;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_BEGIN = 2'd1;
   localparam logic [1:0] REQ_ADD   = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   // register select is paddr[2]
   localparam logic REG_SAMPLE_PERIOD = 1'b0;
   localparam logic REG_SPAN_LEN      = 1'b1;

   localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd64;
   localparam logic [31:0] SPAN_LEN_RESET      = 32'd19200000;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [23:0] window_len;
      logic [11:0] fhr;
      logic [15:0] beat_offset;
      logic [15:0] batch_size;
      logic [15:0] beat_position;
      logic [15:0] kicks;
      logic [9:0]  read_index;
   } req_payload_type;

   typedef struct packed {
      logic [10:0]        beat_total;
      logic [4:0]         window_total;
      logic [27:0]        observed_sum;
      logic [19:0]        kick_sum;
      logic [11:0]        read_rate;
      logic signed [39:0] read_time;
      logic               read_valid;
   } rsp_payload_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic open;
      logic cut_load;
      logic beat_pop;
      logic win_pop;
      logic rebase;
      logic trim;
      logic beat_wr;
      logic win_app;
      logic rd_index;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_kind;
      logic       len_zero;
      logic       cut_pos;
      logic       beat_any;
      logic       win_any;
      logic       beat_old;
      logic       win_old;
      logic       win_full;
      logic       beat_ok;
      logic       beat_last;
      logic       out_free;
   } sts_type;

endpackage

>>> design/ssbts_if.sv
// ----------------------------------------------------------------------------
// ssbts_if: request and response channel interfaces
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ssbts_req_if;
   logic                       valid;
   logic                       ready;
   ssbts_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ssbts_rsp_if;
   logic                       valid;
   logic                       ready;
   ssbts_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/ssbts_ram.sv
// ----------------------------------------------------------------------------
// ssbts_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssbts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ssbts_ctrl.sv
// ----------------------------------------------------------------------------
// ssbts_ctrl: sequencer of the beat trend store
// Steps one request through its datapath commands, one state per step.
// ----------------------------------------------------------------------------
module ssbts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ssbts_pkg::sts_type sts,
   output ssbts_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_CUT       = 4'd2;
   localparam logic [3:0] S_BW_ADDR   = 4'd3;
   localparam logic [3:0] S_BW_CHK    = 4'd4;
   localparam logic [3:0] S_WW_ADDR   = 4'd5;
   localparam logic [3:0] S_WW_CHK    = 4'd6;
   localparam logic [3:0] S_BASE_ADDR = 4'd7;
   localparam logic [3:0] S_BASE      = 4'd8;
   localparam logic [3:0] S_TRIM      = 4'd9;
   localparam logic [3:0] S_BEAT_WR   = 4'd10;
   localparam logic [3:0] S_WPOP_ADDR = 4'd11;
   localparam logic [3:0] S_WPOP      = 4'd12;
   localparam logic [3:0] S_WAPP      = 4'd13;
   localparam logic [3:0] S_RD_ADDR   = 4'd14;
   localparam logic [3:0] S_RD_DATA   = 4'd15;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.req_kind)
               ssbts_pkg::REQ_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = S_RD_ADDR;
               end
               ssbts_pkg::REQ_BEGIN: begin
                  if (sts.len_zero) begin
                     state_in = S_RD_ADDR;
                  end else begin
                     cmd.open = 1'b1;
                     state_in = S_CUT;
                  end
               end
               ssbts_pkg::REQ_ADD: begin
                  state_in = sts.beat_ok ? S_TRIM : S_RD_ADDR;
               end
               default: begin
                  state_in = S_RD_ADDR;
               end
            endcase
         end
         S_CUT: begin
            cmd.cut_load = 1'b1;
            state_in     = S_BW_ADDR;
         end
         S_BW_ADDR: begin
            state_in = (sts.cut_pos && sts.beat_any) ? S_BW_CHK : S_WW_ADDR;
         end
         S_BW_CHK: begin
            if (sts.beat_old) begin
               cmd.beat_pop = 1'b1;
               state_in     = S_BW_ADDR;
            end else begin
               state_in = S_WW_ADDR;
            end
         end
         S_WW_ADDR: begin
            state_in = (sts.cut_pos && sts.win_any) ? S_WW_CHK : S_BASE_ADDR;
         end
         S_WW_CHK: begin
            if (sts.win_old) begin
               cmd.win_pop = 1'b1;
               state_in    = S_WW_ADDR;
            end else begin
               state_in = S_BASE_ADDR;
            end
         end
         S_BASE_ADDR: begin
            state_in = S_BASE;
         end
         S_BASE: begin
            cmd.rebase = 1'b1;
            state_in   = S_RD_ADDR;
         end
         S_TRIM: begin
            cmd.trim = 1'b1;
            state_in = S_BEAT_WR;
         end
         S_BEAT_WR: begin
            cmd.beat_wr = 1'b1;
            if (sts.beat_last) begin
               state_in = sts.win_full ? S_WPOP_ADDR : S_WAPP;
            end else begin
               state_in = S_RD_ADDR;
            end
         end
         S_WPOP_ADDR: begin
            state_in = S_WPOP;
         end
         S_WPOP: begin
            cmd.win_pop = 1'b1;
            state_in    = S_WAPP;
         end
         S_WAPP: begin
            cmd.win_app = 1'b1;
            state_in    = S_RD_ADDR;
         end
         S_RD_ADDR: begin
            cmd.rd_index = 1'b1;
            state_in     = S_RD_DATA;
         end
         S_RD_DATA: begin
            // keep the read address so the RAM output holds while stalled
            cmd.rd_index = 1'b1;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/ssbts_dpath.sv
// ----------------------------------------------------------------------------
// ssbts_dpath: datapath of the beat trend store
// Beat ring and window ring in RAM, frame-offset rebase, running sums and
// the response register.
// ----------------------------------------------------------------------------
module ssbts_dpath #(
   parameter int BEATS_MAX   = 1024,
   parameter int WINDOWS_MAX = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ssbts_pkg::cmd_type         cmd,
   output ssbts_pkg::sts_type         sts,
   input  ssbts_pkg::req_payload_type req_payload,
   input  logic [15:0]                sample_period,
   input  logic [31:0]                span_len,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output ssbts_pkg::rsp_payload_type rsp_payload
);

   localparam int AW  = $clog2(BEATS_MAX);
   localparam int CW  = $clog2(BEATS_MAX + 1);
   localparam int WAW = $clog2(WINDOWS_MAX);
   localparam int WCW = $clog2(WINDOWS_MAX + 1);
   localparam int BDW = ssbts_pkg::RATE_W + ssbts_pkg::TIME_W;
   localparam int WDW = ssbts_pkg::TIME_W + ssbts_pkg::LEN_W + ssbts_pkg::KICK_W;
   localparam logic [16:0] BMAX = 17'(BEATS_MAX);
   localparam logic [8:0]  WMAX = 9'(WINDOWS_MAX);

   ssbts_pkg::req_payload_type req_ff;
   logic [31:0]        prod_ff;
   logic [39:0]        cursor_ff;   // absolute frame
   logic [39:0]        frame_ff;    // rebased = absolute - frame
   logic [23:0]        open_len_ff;
   logic               is_open_ff;
   logic signed [41:0] cutoff_ff;
   logic [AW-1:0]      head_ff;
   logic [CW-1:0]      fill_ff;
   logic [WAW-1:0]     whead_ff;
   logic [WCW-1:0]     wfill_ff;
   logic [ssbts_pkg::OSUM_W-1:0] osum_ff;
   logic [ssbts_pkg::KSUM_W-1:0] ksum_ff;
   logic               rsp_valid_ff;
   ssbts_pkg::rsp_payload_type rsp_ff;

   logic [BDW-1:0] beat_rd;
   logic [WDW-1:0] win_rd;
   logic [AW-1:0]  beat_rd_addr;
   logic [AW-1:0]  beat_wr_addr;
   logic           beat_we;
   logic [WAW-1:0] win_wr_addr;
   logic           win_we;

   logic [16:0] fill_x;
   logic [16:0] ridx_x;
   logic [16:0] ridx_slot;
   logic [16:0] fill_slot;
   logic [16:0] trim_sum;
   logic [16:0] trim_raw;
   logic [16:0] trim_cnt;
   logic [16:0] trim_slot;
   logic        trim_need;
   logic [8:0]  wtail;
   logic [8:0]  whead_nx;
   logic [39:0] cur_reb;
   logic [39:0] beat_reb;
   logic [39:0] win_reb;
   logic [39:0] base;
   logic signed [41:0] cutoff_in;
   logic        rd_valid;

   function automatic logic [16:0] wrap_slot(input logic [16:0] s);
      return (s >= BMAX) ? (s - BMAX) : s;
   endfunction

   assign fill_x    = 17'(fill_ff);
   assign ridx_x    = 17'(req_ff.read_index);
   assign ridx_slot = wrap_slot(17'(head_ff) + ridx_x);
   assign fill_slot = wrap_slot(17'(head_ff) + fill_x);
   assign trim_sum  = fill_x + 17'(req_ff.batch_size);
   assign trim_need = (req_ff.beat_position == 16'd0) && (trim_sum > BMAX);
   assign trim_raw  = trim_sum - BMAX;
   assign trim_cnt  = (trim_raw > fill_x) ? fill_x : trim_raw;
   assign trim_slot = wrap_slot(17'(head_ff) + trim_cnt);
   assign wtail     = (9'(whead_ff) + 9'(wfill_ff) >= WMAX) ?
                      (9'(whead_ff) + 9'(wfill_ff) - WMAX) : (9'(whead_ff) + 9'(wfill_ff));
   assign whead_nx  = (9'(whead_ff) + 9'd1 >= WMAX) ? 9'd0 : (9'(whead_ff) + 9'd1);

   assign cur_reb  = cursor_ff - frame_ff;
   assign beat_reb = beat_rd[39:0] - frame_ff;
   assign win_reb  = win_rd[WDW-1 -: 40] - frame_ff;
   assign cutoff_in = $signed({{2{cur_reb[39]}}, cur_reb})
                    + $signed({18'd0, req_ff.window_len})
                    - $signed({10'd0, span_len});
   assign base = (fill_ff != '0) ? beat_reb : ((wfill_ff != '0) ? win_reb : cur_reb);
   assign rd_valid = ridx_x < fill_x;

   assign beat_rd_addr = cmd.rd_index ? ridx_slot[AW-1:0] : head_ff;
   assign beat_wr_addr = fill_slot[AW-1:0];
   assign beat_we      = cmd.beat_wr && (fill_x < BMAX);
   assign win_wr_addr  = wtail[WAW-1:0];
   assign win_we       = cmd.win_app;

   ssbts_ram #(.WIDTH(BDW), .DEPTH(BEATS_MAX)) u_beat_ram (
      .clock   (clock),
      .wr_en   (beat_we),
      .wr_addr (beat_wr_addr),
      .wr_data ({req_ff.fhr, cursor_ff + {8'd0, prod_ff}}),
      .rd_addr (beat_rd_addr),
      .rd_data (beat_rd)
   );

   ssbts_ram #(.WIDTH(WDW), .DEPTH(WINDOWS_MAX)) u_win_ram (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (win_wr_addr),
      .wr_data ({cursor_ff, open_len_ff, req_ff.kicks}),
      .rd_addr (whead_ff),
      .rd_data (win_rd)
   );

   always_comb begin
      sts.req_kind  = req_ff.req_type;
      sts.len_zero  = (req_ff.window_len == '0);
      sts.cut_pos   = !cutoff_ff[41] && (cutoff_ff != '0);
      sts.beat_any  = (fill_ff != '0);
      sts.win_any   = (wfill_ff != '0);
      sts.beat_old  = $signed({{2{beat_reb[39]}}, beat_reb}) < cutoff_ff;
      sts.win_old   = $signed({{2{win_reb[39]}}, win_reb}) < cutoff_ff;
      sts.win_full  = (9'(wfill_ff) >= WMAX);
      sts.beat_ok   = is_open_ff && (req_ff.batch_size != '0)
                      && (req_ff.beat_position < req_ff.batch_size);
      sts.beat_last = (req_ff.beat_position == req_ff.batch_size - 16'd1);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      prod_ff <= {16'd0, req_ff.beat_offset} * {16'd0, sample_period};
      if (cmd.cut_load) begin
         cutoff_ff <= cutoff_in;
      end
      if (cmd.out_load) begin
         rsp_ff.beat_total   <= fill_x[10:0];
         rsp_ff.window_total <= 5'(wfill_ff);
         rsp_ff.observed_sum <= osum_ff;
         rsp_ff.kick_sum     <= ksum_ff;
         rsp_ff.read_rate    <= rd_valid ? beat_rd[BDW-1 -: 12] : 12'd0;
         rsp_ff.read_time    <= rd_valid ? beat_reb : 40'd0;
         rsp_ff.read_valid   <= rd_valid;
      end
   end

   // store state
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         cursor_ff   <= '0;
         frame_ff    <= '0;
         open_len_ff <= '0;
         is_open_ff  <= 1'b0;
         head_ff     <= '0;
         fill_ff     <= '0;
         whead_ff    <= '0;
         wfill_ff    <= '0;
         osum_ff     <= '0;
         ksum_ff     <= '0;
      end else begin
         if (cmd.open) begin
            if (is_open_ff) begin
               cursor_ff <= cursor_ff + {16'd0, open_len_ff};
            end
            is_open_ff  <= 1'b1;
            open_len_ff <= req_ff.window_len;
         end
         if (cmd.beat_pop) begin
            head_ff <= (17'(head_ff) + 17'd1 >= BMAX) ? '0 : (head_ff + AW'(1));
            fill_ff <= fill_ff - CW'(1);
         end
         if (cmd.trim && trim_need) begin
            head_ff <= trim_slot[AW-1:0];
            fill_ff <= fill_ff - trim_cnt[CW-1:0];
         end
         if (beat_we) begin
            fill_ff <= fill_ff + CW'(1);
         end
         if (cmd.rebase && !base[39] && (base != '0)) begin
            frame_ff <= frame_ff + base;
         end
         if (cmd.win_pop) begin
            whead_ff <= whead_nx[WAW-1:0];
            wfill_ff <= wfill_ff - WCW'(1);
            osum_ff  <= osum_ff - {4'd0, win_rd[39:16]};
            ksum_ff  <= ksum_ff - {4'd0, win_rd[15:0]};
         end
         if (cmd.win_app) begin
            wfill_ff <= wfill_ff + WCW'(1);
            osum_ff  <= osum_ff + {4'd0, open_len_ff};
            ksum_ff  <= ksum_ff + {4'd0, req_ff.kicks};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_x <= BMAX) else $error("beat fill above capacity");
   a_wfill_bound: assert property (@(posedge clock) disable iff (reset)
      9'(wfill_ff) <= WMAX) else $error("window fill above capacity");
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      17'(head_ff) < BMAX) else $error("beat head out of ring");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.beat_pop |-> (fill_ff != '0)) else $error("beat pop on empty ring");
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.win_app |-> (9'(wfill_ff) < WMAX)) else $error("window append when full");

endmodule

>>> design/sliding_span_beat_trend_store_top.sv
// ----------------------------------------------------------------------------
// sliding_span_beat_trend_store_top: sliding-span beat and window store
// Holds timestamped beats and window records over a sliding time span.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request per transfer: clear, begin window, add beat
//   or read beat. Every request yields exactly one rsp_chan transfer with the
//   beat and window counts, the summed window lengths and kicks, and the beat
//   at read_index (times rebased to the oldest retained item at begin window).
//   The APB port sets sample_period (0x0) and span_len (0x4); write it only
//   while no request is in flight.
// Steps, request transfer to rsp_chan.valid (one request at a time):
//   clear, read and ignored requests go from dispatch to the read states. add
//   beat trims, writes the beat and, when it closes the batch, appends a window
//   record, first evicting the oldest one when the window store is full. begin
//   window loads the cutoff, ages out old beats, then old window records, then
//   rebases and reads; RAM reads are registered, so each check is an address state and a compare state.
// Request flow: the next request is taken in the cycle after the response is
//   loaded; no new request is taken before the last one is through.
// Reset: both stores empty, window closed, registers at their defaults.
//   RAM contents need no clearing; only filled entries are read.
// Stall: the response sits in an output register until rsp_chan.ready; the
//   next request may be taken meanwhile, and finishes once the register frees.
// ----------------------------------------------------------------------------
module sliding_span_beat_trend_store_top #(
   parameter int BEATS_MAX   = 1024,
   parameter int WINDOWS_MAX = 16
) (
   input  logic               clock,
   input  logic               reset,
   ssbts_req_if.sink          req_chan,
   ssbts_rsp_if.source        rsp_chan,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   ssbts_pkg::cmd_type cmd;
   ssbts_pkg::sts_type sts;
   logic [15:0]        sample_period_ff;
   logic [31:0]        span_len_ff;
   logic               csr_wr;

   // APB: pready held high, register chosen by paddr[2]
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == ssbts_pkg::REG_SPAN_LEN) ? span_len_ff
                                                         : {16'd0, sample_period_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff <= ssbts_pkg::SAMPLE_PERIOD_RESET;
         span_len_ff      <= ssbts_pkg::SPAN_LEN_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == ssbts_pkg::REG_SAMPLE_PERIOD) begin
            sample_period_ff <= pwdata[15:0];
         end else begin
            span_len_ff <= pwdata;
         end
      end
   end

   // sequencer: one request walks through its states, then back to idle
   ssbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stores, rebase frame, sums and response register
   ssbts_dpath #(
      .BEATS_MAX   (BEATS_MAX),
      .WINDOWS_MAX (WINDOWS_MAX)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_payload   (req_chan.payload),
      .sample_period (sample_period_ff),
      .span_len      (span_len_ff),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_payload   (rsp_chan.payload)
   );

endmodule
